@@ rtl/pfa_pkg.sv @@
package pfa_pkg;

   // Widths fixed by the item fields.
   localparam int FUNC_W  = 1;
   localparam int INDEX_W = 3;
   localparam int FIELD_W = 16;
   localparam int MODE_W  = 2;

   // Input tdata layout: entry_index, entry_size, request_size, padded to bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // Item kinds carried on tuser.
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

   // Fit policies. The unused code behaves as first fit.
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic               active;
      logic               found;
      logic [INDEX_W-1:0] idx;
      logic [FIELD_W-1:0] req;
   } tok_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic               load_en;
      logic               mark_en;
      logic [INDEX_W-1:0] idx;
   } cmd_type;

endpackage

@@ rtl/pfa_cell.sv @@
module pfa_cell #(
   parameter int SIZE_BITS = 16,
   parameter int CELL_IDX  = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              fit_mode,
   input  pfa_pkg::cmd_type        cmd,
   input  logic [SIZE_BITS-1:0]    load_size,
   input  pfa_pkg::tok_type        tok_i,
   input  logic [SIZE_BITS-1:0]    best_i,
   output pfa_pkg::tok_type        tok_o,
   output logic [SIZE_BITS-1:0]    best_o
);
   import pfa_pkg::*;

   localparam int CMP_W = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;
   localparam logic [31:0] MY_IDX = CELL_IDX;

   logic [SIZE_BITS-1:0] size_ff;
   logic                 valid_ff;
   logic                 used_ff;
   tok_type              tok_ff;
   tok_type              tok_in;
   logic [SIZE_BITS-1:0] best_ff;
   logic [SIZE_BITS-1:0] best_in;
   logic                 hit;
   logic                 fits;
   logic                 take;

   assign hit  = (32'(cmd.idx) == MY_IDX);
   assign fits = valid_ff && !used_ff && (CMP_W'(size_ff) >= CMP_W'(tok_i.req));

   // A fitting slot replaces the candidate when none is held yet, or when it is
   // strictly smaller (best fit) or larger (worst fit); equal sizes keep the
   // lower index already held.
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!tok_i.found) begin
            take = 1'b1;
         end else if (fit_mode == FIT_BEST) begin
            take = (size_ff < best_i);
         end else if (fit_mode == FIT_WORST) begin
            take = (size_ff > best_i);
         end
      end
   end

   always_comb begin
      tok_in  = tok_i;
      best_in = best_i;
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.idx   = INDEX_W'(CELL_IDX);
         best_in      = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         used_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         tok_ff <= tok_in;
         if (cmd.load_en && hit) begin
            valid_ff <= 1'b1;
            used_ff  <= 1'b0;
         end else if (cmd.mark_en && hit) begin
            used_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      if (cmd.load_en && hit) begin
         size_ff <= load_size;
      end
   end

   assign tok_o  = tok_ff;
   assign best_o = best_ff;

endmodule

@@ rtl/partition_fit_allocator_unit.sv @@
// Fixed-partition allocator with first, best and worst fit. A load transfer
// (tuser 0) writes a size into one slot and marks it valid and free, and
// produces no result. An allocate transfer (tuser 1) sends a search token
// down a row of NUM_PARTS cells, one cell per cycle, each cell holding one
// slot; the chosen slot is marked used and one result is returned. The first
// cell registers the token at the accepting edge, and the other NUM_PARTS - 1
// cells register it in turn. The outcome is then captured, and the commit
// loads the result register. The commit waits while an earlier result is still
// held on the result channel. The next item is taken at the first edge at
// which the result can transfer. Items are processed one at a time. The fit
// mode is to be written on the csr channel only while the unit is idle; the
// unit itself leaves this to the user.
module partition_fit_allocator_unit #(
   parameter int NUM_PARTS = 8,
   parameter int SIZE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input item channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: entry_index [2:0], entry_size [18:3], request_size [34:19], zero pad.
   input  logic [pfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: func (0 load, 1 allocate).
   input  logic [pfa_pkg::FUNC_W-1:0]         req_tuser,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: granted [0], partition_index [3:1], zero pad.
   output logic [pfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Fit mode register write channel.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfa_pkg::MODE_W-1:0]         csr_data
);
   import pfa_pkg::*;

   localparam int CMP_W = (SIZE_BITS > FIELD_W) ? SIZE_BITS : FIELD_W;
   localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'({SIZE_BITS{1'b1}});

   state_type            state_ff;
   state_type            state_in;
   logic [MODE_W-1:0]    fit_mode_ff;
   logic                 res_found_ff;
   logic                 res_found_in;
   logic [INDEX_W-1:0]   res_idx_ff;
   logic [INDEX_W-1:0]   res_idx_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic [INDEX_W-1:0]   entry_index;
   logic [FIELD_W-1:0]   entry_size;
   logic [FIELD_W-1:0]   request_size;
   logic [CMP_W-1:0]     size_ext;
   logic [SIZE_BITS-1:0] load_size;

   logic                 accept;
   logic                 launch;
   logic                 commit;
   cmd_type              cmd;

   tok_type              tok_chain  [NUM_PARTS+1];
   logic [SIZE_BITS-1:0] best_chain [NUM_PARTS+1];

   assign entry_index  = req_tdata[INDEX_W-1:0];
   assign entry_size   = req_tdata[INDEX_W+FIELD_W-1:INDEX_W];
   assign request_size = req_tdata[INDEX_W+2*FIELD_W-1:INDEX_W+FIELD_W];

   // A load size that does not fit the slot width saturates to its maximum.
   assign size_ext  = CMP_W'(entry_size);
   assign load_size = SIZE_BITS'((size_ext > SIZE_MAX) ? SIZE_MAX : size_ext);

   assign accept = req_tvalid && req_tready;

   // The fit mode register accepts a write in every cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_FIRST;
      end else if (csr_valid) begin
         fit_mode_ff <= csr_data;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_tuser == FUNC_ALLOC)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_chain[NUM_PARTS].active) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      launch     = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            launch     = req_tvalid && (req_tuser == FUNC_ALLOC);
         end
         ST_SCAN: begin
            req_tready = 1'b0;
         end
         ST_DONE: begin
            commit = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Table updates: a load in the accepting cycle, a mark when a grant commits.
   always_comb begin
      cmd.load_en = accept && (req_tuser == FUNC_LOAD);
      cmd.mark_en = commit && res_found_ff;
      cmd.idx     = commit ? res_idx_ff : entry_index;
   end

   // The token enters the first cell straight from the accepted item.
   always_comb begin
      tok_chain[0].active = launch;
      tok_chain[0].found  = 1'b0;
      tok_chain[0].idx    = '0;
      tok_chain[0].req    = request_size;
      best_chain[0]       = '0;
   end

   for (genvar g = 0; g < NUM_PARTS; g++) begin : g_cell
      pfa_cell #(
         .SIZE_BITS (SIZE_BITS),
         .CELL_IDX  (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .fit_mode  (fit_mode_ff),
         .cmd       (cmd),
         .load_size (load_size),
         .tok_i     (tok_chain[g]),
         .best_i    (best_chain[g]),
         .tok_o     (tok_chain[g+1]),
         .best_o    (best_chain[g+1])
      );
   end

   // The outcome is captured when the token leaves the last cell.
   always_comb begin
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      if ((state_ff == ST_SCAN) && tok_chain[NUM_PARTS].active) begin
         res_found_in = tok_chain[NUM_PARTS].found;
         res_idx_in   = tok_chain[NUM_PARTS].idx;
      end
   end

   // Result register: loaded on commit, cleared once the transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'({res_idx_ff, res_found_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
